FILE: hw/rtl/serial_frame_receiver_reassembler_core_assert.svh
// assertion macros used by the port checker
`ifndef SERIAL_FRAME_RECEIVER_REASSEMBLER_CORE_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_REASSEMBLER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SFR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfr assertion failed");

// next-cycle implication, disabled during reset
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfr assertion failed");

`endif

FILE: hw/rtl/sfr_pkg.sv
// shared types and constants of the serial frame receiver
`timescale 1ns / 1ps
package sfr_pkg;
	localparam int FRAME_BYTES_DEF   = 256;
	localparam int MESSAGE_BYTES_DEF = 4096;

	localparam logic [7:0] SYNC_RST   = 8'd30;
	localparam logic [7:0] HOST_RST   = 8'd12;
	localparam logic [7:0] DEVICE_RST = 8'd0;
	localparam logic [7:0] ACK_RST    = 8'd127;

	localparam logic [7:0] SEQ_FIRST  = 8'h40;
	localparam logic [7:0] SEQ_NIBBLE = 8'h0f;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		REG_SYNC   = 2'd0,
		REG_HOST   = 2'd1,
		REG_DEVICE = 2'd2,
		REG_ACK    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_BUSY      = 4'd0,
		ST_SYNC_MISS = 4'd1,
		ST_ADDR_MISS = 4'd2,
		ST_CKS_BAD   = 4'd3,
		ST_ACK_SEEN  = 4'd4,
		ST_FRAG_OK   = 4'd5,
		ST_MSG_DONE  = 4'd6,
		ST_FRAG_MISS = 4'd7,
		ST_TYPE_MISM = 4'd8,
		ST_LEN_BAD   = 4'd9,
		ST_OVERFLOW  = 4'd10,
		ST_READ_DATA = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		K_STATUS = 2'd0,
		K_READ   = 2'd1,
		K_FINISH = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] sync_byte;
		logic [7:0] host_address;
		logic [7:0] device_address;
		logic [7:0] ack_frame_type;
	} cfg_t;

	// one classified word handed from front to back
	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [7:0]  ftype;
		logic        cks_ok;
		logic [15:0] length;
		logic [11:0] read_index;
	} entry_t;
endpackage

FILE: hw/rtl/serial_frame_receiver_reassembler_core.sv
// top level of the serial frame receiver and message reassembler
`timescale 1ns / 1ps
// every word in gives exactly one word out. a line byte or a store read passes the front end
// combinationally into the queue and the back end in two steps (queue pop, then result
// register load). the two-entry queue lets the front end accept new words while the back end
// is busy. the last byte of a frame holds the input stalled until its result is emitted, while
// the back end fetches the sequence and fragment bytes from the frame store and copies the
// payload into the message store one byte per cycle. the input also stalls while the queue is
// full. the result register lets a new word enter while a finished result waits on out_stall.
module serial_frame_receiver_reassembler_core #(
	parameter int FRAME_BYTES   = sfr_pkg::FRAME_BYTES_DEF,
	parameter int MESSAGE_BYTES = sfr_pkg::MESSAGE_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write port
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [7:0]                         cfg_data,
	// input word channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               command,
	input  logic [7:0]                         rx_byte,
	input  logic [11:0]                        read_index,
	// result word channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [3:0]                         status,
	output logic [7:0]                         frame_type,
	output logic [3:0]                         ack_sequence,
	output logic [7:0]                         received_ack_sequence,
	output logic [$clog2(MESSAGE_BYTES+1)-1:0] message_length,
	output logic [7:0]                         read_data
);
	import sfr_pkg::*;

	localparam int FAW = $clog2(FRAME_BYTES);

	cfg_t            cfg_q;
	logic            q_full, q_push, q_pop, q_valid, fin_done;
	entry_t          q_in, q_head;
	logic [FAW-1:0]  fr_addr;
	logic [7:0]      fr_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte      <= SYNC_RST;
			cfg_q.host_address   <= HOST_RST;
			cfg_q.device_address <= DEVICE_RST;
			cfg_q.ack_frame_type <= ACK_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SYNC:   cfg_q.sync_byte      <= cfg_data;
				REG_HOST:   cfg_q.host_address   <= cfg_data;
				REG_DEVICE: cfg_q.device_address <= cfg_data;
				REG_ACK:    cfg_q.ack_frame_type <= cfg_data;
				default: ;
			endcase
		end
	end

	// header parsing and classification
	sfr_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid, .in_stall, .command, .rx_byte, .read_index,
		.q_full, .q_push, .q_data(q_in),
		.fin_done, .fr_addr, .fr_data
	);

	// decoupling queue
	sfr_queue u_queue (
		.clk, .arst_n,
		.push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .head_valid(q_valid), .head(q_head)
	);

	// frame completion, reassembly and results
	sfr_back #(.FRAME_BYTES(FRAME_BYTES), .MESSAGE_BYTES(MESSAGE_BYTES)) u_back (
		.clk, .arst_n, .ack_frame_type(cfg_q.ack_frame_type),
		.head_valid(q_valid), .head(q_head), .pop(q_pop), .fin_done,
		.fr_addr, .fr_data,
		.out_valid, .out_stall, .status, .frame_type, .ack_sequence,
		.received_ack_sequence, .message_length, .read_data
	);
endmodule

FILE: hw/rtl/sfr_front.sv
// front end: header parsing, checksums, frame store and word classification
`timescale 1ns / 1ps
module sfr_front #(
	parameter int FRAME_BYTES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfr_pkg::cfg_t                cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [7:0]                   rx_byte,
	input  logic [11:0]                  read_index,
	input  logic                         q_full,
	output logic                         q_push,
	output sfr_pkg::entry_t              q_data,
	input  logic                         fin_done,
	input  logic [$clog2(FRAME_BYTES)-1:0] fr_addr,
	output logic [7:0]                   fr_data
);
	import sfr_pkg::*;

	localparam int FAW   = $clog2(FRAME_BYTES);
	localparam int CNT_W = $clog2(FRAME_BYTES + 1);

	typedef enum logic [2:0] {
		PH_SYNC, PH_DEST, PH_SRC, PH_TYPE, PH_LEN1, PH_LEN2, PH_BODY
	} phase_t;

	phase_t             phase_q;
	logic [7:0]         cks0_q, cks1_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [15:0]        len_q;
	logic [7:0]         type_q;
	logic               fin_pend_q;
	logic [7:0]         fmem [FRAME_BYTES];

	logic               acc;
	logic [15:0]        len_new;
	logic [16:0]        total_new, total_cur;
	logic [CNT_W-1:0]   cnt_inc;
	logic [7:0]         n0, n1;
	logic               body_end;

	assign in_stall  = q_full | fin_pend_q;
	assign acc       = in_valid & ~in_stall;
	assign len_new   = {len_q[15:8], rx_byte};
	assign total_new = 17'(len_new) + 17'(len_new[0]) + 17'd2;
	assign total_cur = 17'(len_q) + 17'(len_q[0]) + 17'd2;
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign n0        = cnt_q[0] ? cks0_q : (cks0_q ^ rx_byte);
	assign n1        = cnt_q[0] ? (cks1_q ^ rx_byte) : cks1_q;
	assign body_end  = 17'(cnt_inc) >= total_cur;

	always_comb begin
		q_push            = acc;
		q_data            = '0;
		q_data.kind       = K_STATUS;
		q_data.status     = ST_BUSY;
		q_data.read_index = read_index;
		if (command) begin
			q_data.kind   = K_READ;
			q_data.status = ST_READ_DATA;
		end else begin
			unique case (phase_q)
				PH_SYNC: if (rx_byte != cfg.sync_byte) q_data.status = ST_SYNC_MISS;
				PH_DEST: if (rx_byte != cfg.host_address) q_data.status = ST_ADDR_MISS;
				PH_SRC:  if (rx_byte != cfg.device_address) q_data.status = ST_ADDR_MISS;
				PH_LEN2: begin
					if (len_new < 16'd2 || total_new > 17'(FRAME_BYTES)) begin
						q_data.status = ST_LEN_BAD;
						q_data.ftype  = type_q;
					end
				end
				PH_BODY: begin
					if (body_end) begin
						q_data.kind   = K_FINISH;
						q_data.ftype  = type_q;
						q_data.cks_ok = (n0 == 8'd0) && (n1 == 8'd0);
						q_data.length = len_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		fr_data <= fmem[fr_addr];
		if (acc && !command && phase_q == PH_BODY)
			fmem[cnt_q[FAW-1:0]] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SYNC;
			cks0_q     <= '0;
			cks1_q     <= '0;
			cnt_q      <= '0;
			len_q      <= '0;
			type_q     <= '0;
			fin_pend_q <= 1'b0;
		end else begin
			if (fin_done)
				fin_pend_q <= 1'b0;
			if (acc && !command) begin
				unique case (phase_q)
					PH_SYNC: begin
						if (rx_byte == cfg.sync_byte) begin
							cks0_q  <= rx_byte;
							cks1_q  <= '0;
							cnt_q   <= '0;
							phase_q <= PH_DEST;
						end
					end
					PH_DEST: begin
						if (rx_byte == cfg.host_address) begin
							cks1_q  <= cks1_q ^ rx_byte;
							phase_q <= PH_SRC;
						end else
							phase_q <= PH_SYNC;
					end
					PH_SRC: begin
						if (rx_byte == cfg.device_address) begin
							cks0_q  <= cks0_q ^ rx_byte;
							phase_q <= PH_TYPE;
						end else
							phase_q <= PH_SYNC;
					end
					PH_TYPE: begin
						cks1_q  <= cks1_q ^ rx_byte;
						type_q  <= rx_byte;
						phase_q <= PH_LEN1;
					end
					PH_LEN1: begin
						cks0_q  <= cks0_q ^ rx_byte;
						len_q   <= {rx_byte, 8'd0};
						phase_q <= PH_LEN2;
					end
					PH_LEN2: begin
						cks1_q <= cks1_q ^ rx_byte;
						len_q  <= len_new;
						cnt_q  <= '0;
						if (len_new < 16'd2 || total_new > 17'(FRAME_BYTES))
							phase_q <= PH_SYNC;
						else
							phase_q <= PH_BODY;
					end
					PH_BODY: begin
						cks0_q <= n0;
						cks1_q <= n1;
						cnt_q  <= cnt_inc;
						if (body_end) begin
							phase_q    <= PH_SYNC;
							fin_pend_q <= 1'b1;
						end
					end
					default: phase_q <= PH_SYNC;
				endcase
			end
		end
	end
endmodule

FILE: hw/rtl/sfr_queue.sv
// two-entry queue between front and back
`timescale 1ns / 1ps
module sfr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfr_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output sfr_pkg::entry_t head
);
	import sfr_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	entry_t              mem_q [QDEPTH];
	logic [PW-1:0]       wp_q, rp_q;
	logic [PW:0]         cnt_q;

	assign full       = cnt_q == (PW+1)'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= wp_q + PW'(1);
			if (pop)
				rp_q <= rp_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (PW+1)'(1);
		end
	end
endmodule

FILE: hw/rtl/sfr_back.sv
// back end: frame completion, message store and result register
`timescale 1ns / 1ps
module sfr_back #(
	parameter int FRAME_BYTES   = 256,
	parameter int MESSAGE_BYTES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [7:0]                            ack_frame_type,
	input  logic                                  head_valid,
	input  sfr_pkg::entry_t                       head,
	output logic                                  pop,
	output logic                                  fin_done,
	output logic [$clog2(FRAME_BYTES)-1:0]        fr_addr,
	input  logic [7:0]                            fr_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [3:0]                            status,
	output logic [7:0]                            frame_type,
	output logic [3:0]                            ack_sequence,
	output logic [7:0]                            received_ack_sequence,
	output logic [$clog2(MESSAGE_BYTES+1)-1:0]    message_length,
	output logic [7:0]                            read_data
);
	import sfr_pkg::*;

	localparam int FAW    = $clog2(FRAME_BYTES);
	localparam int MAW    = $clog2(MESSAGE_BYTES);
	localparam int FILL_W = $clog2(MESSAGE_BYTES + 1);

	typedef enum logic [2:0] {S_IDLE, S_F1, S_F2, S_F3, S_COPY, S_EMIT} state_t;

	state_t            state_q;
	entry_t            cur_q;
	logic [7:0]        mrd_q;
	logic [7:0]        seq_q;
	logic [FAW-1:0]    addr_q;
	logic [FAW-1:0]    pay_q;
	logic [FILL_W-1:0] base_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        frag_q;
	logic [7:0]        mtype_q;
	status_t           st_q;
	logic [3:0]        ack_q;
	logic [7:0]        rxa_q;
	logic              cp_v_s1;
	logic [MAW-1:0]    cp_wa_s1;
	logic [7:0]        mmem [MESSAGE_BYTES];

	logic              emit_go;
	logic [FAW-1:0]    len_c;
	logic              first;
	logic [7:0]        frag_c, frag_dec;
	logic [FILL_W-1:0] base_c;
	logic [FILL_W:0]   end_c;
	logic [31:0]       hidx, cidx;

	assign emit_go  = state_q == S_EMIT && (!out_valid || !out_stall);
	assign pop      = state_q == S_IDLE && head_valid;
	assign fin_done = emit_go && cur_q.kind == K_FINISH;
	assign fr_addr  = addr_q;
	assign len_c    = cur_q.length[FAW-1:0];
	assign first    = (seq_q & SEQ_FIRST) == SEQ_FIRST;
	assign frag_c   = first ? fr_data : frag_q;
	assign frag_dec = frag_c - 8'd1;
	assign base_c   = first ? '0 : fill_q;
	assign end_c    = (FILL_W+1)'(base_c) + (FILL_W+1)'(pay_q);
	// read address follows the word being popped, then the word held for emit
	assign hidx     = 32'((state_q == S_IDLE) ? head.read_index : cur_q.read_index);
	assign cidx     = 32'(cur_q.read_index);

	always_ff @(posedge clk) begin
		mrd_q <= mmem[hidx[MAW-1:0]];
		if (cp_v_s1)
			mmem[cp_wa_s1] <= fr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			seq_q     <= '0;
			addr_q    <= '0;
			pay_q     <= '0;
			base_q    <= '0;
			fill_q    <= '0;
			frag_q    <= '0;
			mtype_q   <= '0;
			st_q      <= ST_BUSY;
			ack_q     <= '0;
			rxa_q     <= '0;
			cp_v_s1   <= 1'b0;
			cp_wa_s1  <= '0;
			out_valid <= 1'b0;
			status    <= '0;
			frame_type <= '0;
			ack_sequence <= '0;
			received_ack_sequence <= '0;
			message_length <= '0;
			read_data <= '0;
		end else begin
			cp_v_s1 <= 1'b0;
			if (out_valid && !out_stall && !emit_go)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						cur_q <= head;
						st_q  <= (head.kind == K_FINISH && !head.cks_ok) ? ST_CKS_BAD
							: head.status;
						ack_q <= '0;
						rxa_q <= '0;
						addr_q <= head.length[FAW-1:0] - FAW'(1);
						pay_q  <= head.length[FAW-1:0] - FAW'(2);
						if (head.kind == K_FINISH && head.cks_ok)
							state_q <= S_F1;
						else
							state_q <= S_EMIT;
					end
				end
				S_F1: begin
					addr_q  <= len_c - FAW'(2);
					state_q <= S_F2;
				end
				S_F2: begin
					seq_q <= fr_data;
					if (cur_q.ftype == ack_frame_type) begin
						st_q    <= ST_ACK_SEEN;
						rxa_q   <= fr_data;
						state_q <= S_EMIT;
					end else
						state_q <= S_F3;
				end
				S_F3: begin
					// fr_data holds the fragment count here
					if (first)
						mtype_q <= cur_q.ftype;
					if (!first && frag_q != fr_data) begin
						st_q    <= ST_FRAG_MISS;
						state_q <= S_EMIT;
					end else if (!first && cur_q.ftype != mtype_q) begin
						st_q    <= ST_TYPE_MISM;
						state_q <= S_EMIT;
					end else if (end_c > (FILL_W+1)'(MESSAGE_BYTES)) begin
						st_q    <= ST_OVERFLOW;
						fill_q  <= '0;
						frag_q  <= '0;
						state_q <= S_EMIT;
					end else begin
						base_q  <= base_c;
						fill_q  <= end_c[FILL_W-1:0];
						frag_q  <= frag_dec;
						ack_q   <= seq_q[3:0] & SEQ_NIBBLE[3:0];
						st_q    <= (frag_dec == 8'd0) ? ST_MSG_DONE : ST_FRAG_OK;
						addr_q  <= '0;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					// read frame byte at addr_q; it is written in the next cycle
					if (addr_q == pay_q)
						state_q <= S_EMIT;
					else begin
						cp_v_s1  <= 1'b1;
						cp_wa_s1 <= MAW'(base_q) + MAW'(addr_q);
						addr_q   <= addr_q + FAW'(1);
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid    <= 1'b1;
						status       <= st_q;
						ack_sequence <= ack_q;
						received_ack_sequence <= rxa_q;
						message_length <= fill_q;
						frame_type <= (cur_q.kind == K_FINISH || st_q == ST_LEN_BAD)
							? cur_q.ftype : 8'd0;
						read_data <= (cur_q.kind == K_READ && cidx < 32'(fill_q))
							? mrd_q : 8'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/sfr_checker.sv
// port-level checks for the frame receiver core
`timescale 1ns / 1ps
`include "serial_frame_receiver_reassembler_core_assert.svh"
module sfr_checker #(
	parameter int FILL_W = 13
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [3:0]        status,
	input logic [7:0]        frame_type,
	input logic [3:0]        ack_sequence,
	input logic [7:0]        received_ack_sequence,
	input logic [FILL_W-1:0] message_length,
	input logic [7:0]        read_data
);
	import sfr_pkg::*;

	`SFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
	`SFR_ASSERT_NOW(a_rxack_only_ack, out_valid && status != ST_ACK_SEEN, received_ack_sequence == 8'd0)
	`SFR_ASSERT_NOW(a_ackseq_only_frag, out_valid && status != ST_FRAG_OK && status != ST_MSG_DONE, ack_sequence == 4'd0)
	`SFR_ASSERT_NOW(a_rdata_only_read, out_valid && status != ST_READ_DATA, read_data == 8'd0)
	`SFR_ASSERT_NOW(a_overflow_clears, out_valid && status == ST_OVERFLOW, message_length == '0)
endmodule

bind serial_frame_receiver_reassembler_core sfr_checker #(
	.FILL_W($clog2(MESSAGE_BYTES + 1))
) u_sfr_checker (.*);
